### hw/rtl/spim_pkg.sv
`default_nettype none

package spim_pkg;

  localparam int MAX_WORD_BITS_DEF = 16;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [2:0] REG_CPOL  = 3'd0;
  localparam logic [2:0] REG_CPHA  = 3'd1;
  localparam logic [2:0] REG_MSB   = 3'd2;
  localparam logic [2:0] REG_3WIRE = 3'd3;
  localparam logic [2:0] REG_WIDE  = 3'd4;
  localparam logic [2:0] REG_HALF  = 3'd5;

  typedef struct packed {
    logic        cpol;
    logic        cpha;
    logic        msb_first;
    logic        three_wire;
    logic        wide_words;
    logic [7:0]  half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] tx_word;
    logic        tx_present;
    logic        rx_wanted;
    logic        cs_take;
    logic        cs_end;
    logic        last_word;
    logic        miso_level;
    logic        shared_line_level;
  } item_t;

  typedef struct packed {
    logic        sclk;
    logic        mosi;
    logic        mosi_drive;
    logic        cs_n;
    logic [15:0] rx_word;
    logic        rx_valid;
    logic        busy_res;
    logic        rejected;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/spim_regs.sv
`default_nettype none

module spim_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spim_pkg::PADDR_W-1:0] paddr,
  input  wire logic [spim_pkg::PDATA_W-1:0] pwdata,
  output logic      [spim_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output spim_pkg::cfg_t                   cfg_o,
  output logic                             pol_wr_o,
  output logic                             pol_val_o
);
  import spim_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CPOL:  cfg_nxt.cpol              = pwdata[0];
        REG_CPHA:  cfg_nxt.cpha              = pwdata[0];
        REG_MSB:   cfg_nxt.msb_first         = pwdata[0];
        REG_3WIRE: cfg_nxt.three_wire        = pwdata[0];
        REG_WIDE:  cfg_nxt.wide_words        = pwdata[0];
        REG_HALF:  cfg_nxt.half_period_ticks = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CPOL:  prdata = PDATA_W'(cfg_r.cpol);
      REG_CPHA:  prdata = PDATA_W'(cfg_r.cpha);
      REG_MSB:   prdata = PDATA_W'(cfg_r.msb_first);
      REG_3WIRE: prdata = PDATA_W'(cfg_r.three_wire);
      REG_WIDE:  prdata = PDATA_W'(cfg_r.wide_words);
      REG_HALF:  prdata = PDATA_W'(cfg_r.half_period_ticks);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpol              <= 1'b0;
      cfg_r.cpha              <= 1'b0;
      cfg_r.msb_first         <= 1'b1;
      cfg_r.three_wire        <= 1'b0;
      cfg_r.wide_words        <= 1'b0;
      cfg_r.half_period_ticks <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o     = cfg_r;
  assign pol_wr_o  = wr_en && (reg_idx == REG_CPOL);
  assign pol_val_o = pwdata[0];

endmodule

`default_nettype wire

### hw/rtl/spim_engine.sv
`default_nettype none

module spim_engine #(
  parameter int MAX_WORD_BITS = spim_pkg::MAX_WORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step_i,
  input  spim_pkg::item_t      item_i,
  input  spim_pkg::cfg_t       cfg_i,
  input  wire logic            pol_wr_i,
  input  wire logic            pol_val_i,
  output spim_pkg::res_t       res_o
);
  import spim_pkg::*;

  localparam int W    = MAX_WORD_BITS;
  localparam int BCW  = $clog2(W + 1);
  localparam int IDXW = $clog2(W);

  typedef enum logic [3:0] {
    PH_IDLE, PH_SETUP_WAIT, PH_LEAD_WAIT, PH_LEAD_TOGGLE, PH_DRIVE, PH_PRE_WAIT,
    PH_EDGE1, PH_POST_WAIT, PH_EDGE2, PH_HOLD_WAIT, PH_RELEASE
  } phase_t;

  typedef struct packed {
    logic wide;
    logic tw;
    logic last;
    logic rel;
    logic rx;
  } flags_t;

  phase_t         phase_r, phase_nxt, cur_ph, setup_ph;
  flags_t         fl_r, fl_nxt;
  logic [BCW-1:0] bc_r, bc_nxt, bc_inc, nbits, idx;
  logic [IDXW-1:0] bsel;
  logic [W-1:0]   tx_r, tx_nxt, rx_r, rx_nxt, mask, new_mask, rx_done, rx_lsb;
  logic [7:0]     wait_r, wait_nxt, wait_dec, cs_ticks;
  logic [8:0]     hp_inc;
  logic           clk_lvl_r, clk_lvl_nxt;
  logic           data_r, data_nxt;
  logic           drv_r, drv_nxt;
  logic           sel_r, sel_nxt;
  logic           samp_bit, final_bit, expired, done;

  assign cur_ph   = (phase_r > PH_RELEASE) ? PH_IDLE : phase_r;
  assign nbits    = fl_r.wide ? BCW'(W) : BCW'(8);
  assign mask     = fl_r.wide ? {W{1'b1}} : W'(8'hFF);
  assign new_mask = cfg_i.wide_words ? {W{1'b1}} : W'(8'hFF);
  assign idx      = (bc_r < nbits) ? bc_r : nbits - 1'b1;
  assign bsel     = cfg_i.msb_first ? IDXW'(nbits - 1'b1 - idx) : IDXW'(idx);
  assign hp_inc   = {1'b0, cfg_i.half_period_ticks} + 9'd1;
  assign cs_ticks = hp_inc[8:1];
  assign wait_dec = (wait_r != 8'd0) ? wait_r - 8'd1 : 8'd0;
  assign expired  = (wait_dec == 8'd0);
  assign samp_bit = fl_r.tw ? item_i.shared_line_level : item_i.miso_level;
  assign bc_inc   = bc_r + 1'b1;
  assign final_bit = (bc_inc >= nbits);
  assign rx_done  = (fl_r.tw && drv_r) ? tx_r : rx_r;
  assign setup_ph = !cfg_i.cpha ? PH_DRIVE :
                    ((cs_ticks == 8'd0) ? PH_LEAD_TOGGLE : PH_LEAD_WAIT);

  always_comb begin
    rx_lsb = rx_r >> 1;
    if (fl_r.wide) begin
      rx_lsb[W-1] = samp_bit;
    end else begin
      rx_lsb[7] = samp_bit;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    fl_nxt      = fl_r;
    bc_nxt      = bc_r;
    tx_nxt      = tx_r;
    rx_nxt      = rx_r;
    wait_nxt    = wait_r;
    clk_lvl_nxt = clk_lvl_r;
    data_nxt    = data_r;
    drv_nxt     = drv_r;
    sel_nxt     = sel_r;
    done        = 1'b0;
    if (step_i) begin
      phase_nxt = cur_ph;
      unique case (cur_ph)
        PH_IDLE: begin
          if (item_i.kind) begin
            fl_nxt = '{wide: cfg_i.wide_words, tw: cfg_i.three_wire, last: item_i.last_word,
                       rel: item_i.cs_end, rx: item_i.rx_wanted};
            tx_nxt = item_i.tx_present ? (W'(item_i.tx_word) & new_mask) : new_mask;
            rx_nxt = new_mask;
            bc_nxt = '0;
            drv_nxt = !(cfg_i.three_wire && !item_i.tx_present && item_i.rx_wanted);
            if (item_i.cs_take) begin
              sel_nxt = 1'b0;
              if (cs_ticks == 8'd0) begin
                phase_nxt = setup_ph;
              end else begin
                phase_nxt = PH_SETUP_WAIT;
              end
              wait_nxt = cs_ticks;
            end else begin
              phase_nxt = PH_DRIVE;
            end
          end
        end
        PH_SETUP_WAIT: begin
          wait_nxt = wait_dec;
          if (expired) begin
            phase_nxt = setup_ph;
            if (setup_ph == PH_LEAD_WAIT) begin
              wait_nxt = cs_ticks;
            end
          end
        end
        PH_LEAD_WAIT: begin
          wait_nxt = wait_dec;
          if (expired) begin
            phase_nxt = PH_LEAD_TOGGLE;
          end
        end
        PH_LEAD_TOGGLE: begin
          clk_lvl_nxt = !clk_lvl_r;
          phase_nxt   = PH_DRIVE;
        end
        PH_DRIVE: begin
          if (drv_r) begin
            data_nxt = tx_r[bsel];
          end
          wait_nxt  = cfg_i.half_period_ticks;
          phase_nxt = (cfg_i.half_period_ticks == 8'd0) ? PH_EDGE1 : PH_PRE_WAIT;
        end
        PH_PRE_WAIT: begin
          wait_nxt = wait_dec;
          if (expired) begin
            phase_nxt = PH_EDGE1;
          end
        end
        PH_EDGE1: begin
          clk_lvl_nxt = !clk_lvl_r;
          if (!fl_r.tw || !drv_r) begin
            rx_nxt = cfg_i.msb_first ? ({rx_r[W-2:0], samp_bit} & mask) : (rx_lsb & mask);
          end
          wait_nxt  = cfg_i.half_period_ticks;
          phase_nxt = (cfg_i.half_period_ticks == 8'd0) ? PH_EDGE2 : PH_POST_WAIT;
        end
        PH_POST_WAIT: begin
          wait_nxt = wait_dec;
          if (expired) begin
            phase_nxt = PH_EDGE2;
          end
        end
        PH_EDGE2: begin
          if (!(cfg_i.cpha && fl_r.last && final_bit)) begin
            clk_lvl_nxt = !clk_lvl_r;
          end
          bc_nxt = bc_inc;
          if (!final_bit) begin
            phase_nxt = PH_DRIVE;
          end else if (fl_r.rel) begin
            wait_nxt  = cs_ticks;
            phase_nxt = (cs_ticks == 8'd0) ? PH_RELEASE : PH_HOLD_WAIT;
          end else begin
            done = 1'b1;
          end
        end
        PH_HOLD_WAIT: begin
          wait_nxt = wait_dec;
          if (expired) begin
            phase_nxt = PH_RELEASE;
          end
        end
        PH_RELEASE: begin
          sel_nxt = 1'b1;
          done    = 1'b1;
        end
        default: ;
      endcase
      if (done) begin
        rx_nxt    = rx_done;
        drv_nxt   = 1'b1;
        bc_nxt    = '0;
        phase_nxt = PH_IDLE;
      end
    end else if (pol_wr_i && (phase_r == PH_IDLE)) begin
      clk_lvl_nxt = pol_val_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      fl_r      <= '0;
      bc_r      <= '0;
      wait_r    <= 8'd0;
      clk_lvl_r <= 1'b0;
      data_r    <= 1'b0;
      drv_r     <= 1'b1;
      sel_r     <= 1'b1;
      tx_r      <= {W{1'b1}};
      rx_r      <= {W{1'b1}};
    end else begin
      phase_r   <= phase_nxt;
      fl_r      <= fl_nxt;
      bc_r      <= bc_nxt;
      wait_r    <= wait_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      data_r    <= data_nxt;
      drv_r     <= drv_nxt;
      sel_r     <= sel_nxt;
      tx_r      <= tx_nxt;
      rx_r      <= rx_nxt;
    end
  end

  always_comb begin
    res_o.sclk       = clk_lvl_nxt;
    res_o.mosi       = data_nxt;
    res_o.mosi_drive = drv_nxt;
    res_o.cs_n       = sel_nxt;
    res_o.rx_valid   = done && fl_r.rx;
    res_o.rx_word    = (done && fl_r.rx) ? 16'(rx_done) : 16'd0;
    res_o.busy_res   = (phase_nxt != PH_IDLE);
    res_o.rejected   = item_i.kind && (cur_ph != PH_IDLE);
  end

  a_idle_drives: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> drv_r)
    else $error("data line released while idle");

  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bc_r == '0))
    else $error("bit count not cleared while idle");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DRIVE) |-> (bc_r < nbits))
    else $error("bit count beyond word size in drive phase");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && res_o.rx_valid) |-> !res_o.busy_res)
    else $error("received word reported while still busy");

endmodule

`default_nettype wire

### hw/rtl/spi_master_shifter.sv
// A tick transfer is captured in the input register; when the output is free, the
// engine step loads its result into the output register, which raises out_tvalid.
// Throughput: one tick per clock cycle while out_tready does not stall the output;
// the engine step is combinational between the input and output registers.
// Reset (rst_n low, synchronous): idle, sclk at polarity 0, cs_n high, data driven,
// configuration back to defaults, both registers empty.
`default_nettype none

module spi_master_shifter #(
  parameter int MAX_WORD_BITS = spim_pkg::MAX_WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tx_word[15:0], tx_present[16], rx_wanted[17], cs_take[18], cs_end[19],
  // miso_level[20], shared_line_level[21], zeros above
  input  wire logic [spim_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  wire logic                           in_tuser,
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // sclk[0], mosi[1], mosi_drive[2], cs_n[3], rx_word[19:4], busy_res[20],
  // rejected[21], zeros above
  output logic      [spim_pkg::OUT_DATA_W-1:0] out_tdata,
  // rx_valid[0]
  output logic                                out_tuser,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [spim_pkg::PADDR_W-1:0]    cfg_paddr,
  input  wire logic [spim_pkg::PDATA_W-1:0]    cfg_pwdata,
  output logic      [spim_pkg::PDATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);
  import spim_pkg::*;

  item_t item_r;
  item_t item_nxt;
  res_t  res_nxt;
  res_t  res_r;
  cfg_t  cfg;
  logic  in_valid_r;
  logic  out_valid_r;
  logic  step;
  logic  pol_wr;
  logic  pol_val;

  spim_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .pready    (cfg_pready),
    .cfg_o     (cfg),
    .pol_wr_o  (pol_wr),
    .pol_val_o (pol_val)
  );

  spim_engine #(
    .MAX_WORD_BITS (MAX_WORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step),
    .item_i    (item_r),
    .cfg_i     (cfg),
    .pol_wr_i  (pol_wr),
    .pol_val_i (pol_val),
    .res_o     (res_nxt)
  );

  assign step      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step;

  always_comb begin
    item_nxt.kind              = in_tuser;
    item_nxt.tx_word           = in_tdata[15:0];
    item_nxt.tx_present        = in_tdata[16];
    item_nxt.rx_wanted         = in_tdata[17];
    item_nxt.cs_take           = in_tdata[18];
    item_nxt.cs_end            = in_tdata[19];
    item_nxt.last_word         = in_tlast;
    item_nxt.miso_level        = in_tdata[20];
    item_nxt.shared_line_level = in_tdata[21];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.rx_valid;
  assign out_tdata  = {2'b00, res_r.rejected, res_r.busy_res, res_r.rx_word,
                       res_r.cs_n, res_r.mosi_drive, res_r.mosi, res_r.sclk};

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import spim_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int LONG_PHASE = 4;
  localparam int PHASE_TICKS = 110;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP_WAIT, ST_LEAD_WAIT, ST_LEAD_EDGE, ST_DRIVE, ST_PRE_WAIT,
    ST_EDGE1, ST_POST_WAIT, ST_EDGE2, ST_HOLD_WAIT, ST_RELEASE
  } engine_state_t;

  typedef struct packed {
    item_t tick;
    int    reps;
    bit    typed;
    res_t  want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [PADDR_W-1:0]    cfg_paddr;
  logic [PDATA_W-1:0]    cfg_pwdata;
  logic [PDATA_W-1:0]    cfg_prdata;
  logic                  cfg_pready;

  cfg_t          live_cfg;
  engine_state_t eng_state;
  logic [4:0]    bit_idx;
  logic [15:0]   tx_sr;
  logic [15:0]   rx_sr;
  logic [7:0]    wait_cnt;
  logic          sclk_lvl, mosi_lvl, drive_lvl, cs_lvl;
  logic          w_rx, w_rel, w_last, w_3w, w_wide;

  res_t      expected_pin_states[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        in_idle_on = 1'b1;
  bit        out_idle_on = 1'b1;
  plan_row_t plan [5];

  spi_master_shifter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] cs_hold();
    return 8'((9'(live_cfg.half_period_ticks) + 9'd1) >> 1);
  endfunction

  function automatic void leave_setup();
    if (!live_cfg.cpha) begin
      eng_state = ST_DRIVE;
    end else if (cs_hold() == 8'd0) begin
      eng_state = ST_LEAD_EDGE;
    end else begin
      eng_state = ST_LEAD_WAIT;
      wait_cnt = cs_hold();
    end
  endfunction

  function automatic bit wait_done();
    if (wait_cnt != 8'd0) wait_cnt = wait_cnt - 8'd1;
    return wait_cnt == 8'd0;
  endfunction

  function automatic void wait_then(engine_state_t wait_st, logic [7:0] n,
                                    engine_state_t next_st);
    if (n == 8'd0) begin
      eng_state = next_st;
    end else begin
      eng_state = wait_st;
      wait_cnt = n;
    end
  endfunction

  function automatic res_t advance_spi_engine(item_t t);
    res_t        r;
    logic [15:0] word_mask;
    int          n;
    int          pos;
    logic        smp;
    logic        last_bit;
    logic        done;
    r = '0;
    done = 1'b0;
    r.rejected = t.kind && (eng_state != ST_IDLE);
    n = w_wide ? MAX_WORD_BITS_DEF : 8;
    word_mask = w_wide ? 16'hFFFF : 16'h00FF;
    case (eng_state)
      ST_IDLE: begin
        if (t.kind) begin
          w_rx = t.rx_wanted;
          w_rel = t.cs_end;
          w_last = t.last_word;
          w_3w = live_cfg.three_wire;
          w_wide = live_cfg.wide_words;
          word_mask = w_wide ? 16'hFFFF : 16'h00FF;
          tx_sr = t.tx_present ? (t.tx_word & word_mask) : word_mask;
          rx_sr = word_mask;
          bit_idx = '0;
          drive_lvl = !(live_cfg.three_wire && !t.tx_present && t.rx_wanted);
          if (t.cs_take) begin
            cs_lvl = 1'b0;
            if (cs_hold() == 8'd0) begin
              leave_setup();
            end else begin
              eng_state = ST_SETUP_WAIT;
              wait_cnt = cs_hold();
            end
          end else begin
            eng_state = ST_DRIVE;
          end
        end
      end
      ST_SETUP_WAIT: if (wait_done()) leave_setup();
      ST_LEAD_WAIT: if (wait_done()) eng_state = ST_LEAD_EDGE;
      ST_LEAD_EDGE: begin
        sclk_lvl = !sclk_lvl;
        eng_state = ST_DRIVE;
      end
      ST_DRIVE: begin
        pos = (int'(bit_idx) < n) ? int'(bit_idx) : n - 1;
        if (drive_lvl) mosi_lvl = tx_sr[live_cfg.msb_first ? n - 1 - pos : pos];
        wait_then(ST_PRE_WAIT, live_cfg.half_period_ticks, ST_EDGE1);
      end
      ST_PRE_WAIT: if (wait_done()) eng_state = ST_EDGE1;
      ST_EDGE1: begin
        sclk_lvl = !sclk_lvl;
        if (!w_3w || !drive_lvl) begin
          smp = w_3w ? t.shared_line_level : t.miso_level;
          if (live_cfg.msb_first) rx_sr = {rx_sr[14:0], smp} & word_mask;
          else rx_sr = ((rx_sr >> 1) | (16'(smp) << (n - 1))) & word_mask;
        end
        wait_then(ST_POST_WAIT, live_cfg.half_period_ticks, ST_EDGE2);
      end
      ST_POST_WAIT: if (wait_done()) eng_state = ST_EDGE2;
      ST_EDGE2: begin
        last_bit = (int'(bit_idx) + 1 >= n);
        if (!(live_cfg.cpha && w_last && last_bit)) sclk_lvl = !sclk_lvl;
        bit_idx = bit_idx + 5'd1;
        if (!last_bit) begin
          eng_state = ST_DRIVE;
        end else if (w_rel) begin
          wait_then(ST_HOLD_WAIT, cs_hold(), ST_RELEASE);
        end else begin
          done = 1'b1;
        end
      end
      ST_HOLD_WAIT: if (wait_done()) eng_state = ST_RELEASE;
      default: begin
        cs_lvl = 1'b1;
        done = 1'b1;
      end
    endcase
    if (done) begin
      // A word that was driven on the shared line reports its own data.
      if (w_3w && drive_lvl) rx_sr = tx_sr;
      if (w_rx) begin
        r.rx_valid = 1'b1;
        r.rx_word = rx_sr;
      end
      drive_lvl = 1'b1;
      bit_idx = '0;
      eng_state = ST_IDLE;
    end
    r.sclk = sclk_lvl;
    r.mosi = mosi_lvl;
    r.mosi_drive = drive_lvl;
    r.cs_n = cs_lvl;
    r.busy_res = (eng_state != ST_IDLE);
    return r;
  endfunction

  function automatic item_t random_tick();
    item_t t;
    t.kind = (eng_state == ST_IDLE) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
    t.tx_word = 16'($urandom);
    t.tx_present = ($urandom_range(0, 3) != 0);
    t.rx_wanted = 1'($urandom_range(0, 1));
    t.cs_take = 1'($urandom_range(0, 1));
    t.cs_end = 1'($urandom_range(0, 1));
    t.last_word = 1'($urandom_range(0, 1));
    t.miso_level = 1'($urandom_range(0, 1));
    t.shared_line_level = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(input item_t t, input res_t want);
    int gap;
    if ($urandom_range(0, 31) == 0) in_idle_on = !in_idle_on;
    gap = in_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, t.shared_line_level, t.miso_level, t.cs_end, t.cs_take,
                 t.rx_wanted, t.tx_present, t.tx_word};
    in_tuser <= t.kind;
    in_tlast <= t.last_word;
    do @(posedge clk); while (!in_tready);
    expected_pin_states.push_back(want);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_pin_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_CPOL: begin
        live_cfg.cpol = val[0];
        if (eng_state == ST_IDLE) sclk_lvl = val[0];
      end
      REG_CPHA: live_cfg.cpha = val[0];
      REG_MSB: live_cfg.msb_first = val[0];
      REG_3WIRE: live_cfg.three_wire = val[0];
      REG_WIDE: live_cfg.wide_words = val[0];
      REG_HALF: live_cfg.half_period_ticks = val;
      default: ;
    endcase
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(REG_CPOL, {7'd0, c.cpol});
    write_reg(REG_CPHA, {7'd0, c.cpha});
    write_reg(REG_MSB, {7'd0, c.msb_first});
    write_reg(REG_3WIRE, {7'd0, c.three_wire});
    write_reg(REG_WIDE, {7'd0, c.wide_words});
    write_reg(REG_HALF, c.half_period_ticks);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pin_states.size() == 0) begin
        $error("out transfer with nothing pending, tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = expected_pin_states.pop_front();
        check_field("sclk", want.sclk, out_tdata[0]);
        check_field("mosi", want.mosi, out_tdata[1]);
        check_field("mosi_drive", want.mosi_drive, out_tdata[2]);
        check_field("cs_n", want.cs_n, out_tdata[3]);
        check_field("rx_word", want.rx_word, out_tdata[19:4]);
        check_field("rx_valid", want.rx_valid, out_tuser);
        check_field("busy_res", want.busy_res, out_tdata[20]);
        check_field("rejected", want.rejected, out_tdata[21]);
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) out_idle_on = !out_idle_on;
      stall = out_idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    item_t t;
    cfg_t  c;
    int    r;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= 1'b0;
    in_tlast <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    live_cfg = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0};
    eng_state = ST_IDLE;
    bit_idx = '0;
    tx_sr = 16'hFFFF;
    rx_sr = 16'hFFFF;
    wait_cnt = '0;
    sclk_lvl = 1'b0;
    mosi_lvl = 1'b0;
    drive_lvl = 1'b1;
    cs_lvl = 1'b1;
    {w_rx, w_rel, w_last, w_3w, w_wide} = '0;

    // Fields: kind, tx_word, tx_present, rx_wanted, cs_take, cs_end, last_word,
    // miso_level, shared_line_level. Results: sclk, mosi, mosi_drive, cs_n, rx_word,
    // rx_valid, busy_res, rejected.
    plan[0] = '{'{1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1, 1'b1,
                '{1'b0, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0}};
    plan[1] = '{'{1'b1, 16'h00A5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1, 1'b1,
                '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0}};
    plan[2] = '{'{1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1, 1'b1,
                '{1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b1}};
    plan[3] = '{'{1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 23, 1'b0,
                '0};
    plan[4] = '{'{1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}, 1, 1'b1,
                '{1'b0, 1'b1, 1'b1, 1'b1, 16'h00FF, 1'b1, 1'b0, 1'b0}};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        if (plan[i].typed) begin
          void'(advance_spi_engine(plan[i].tick));
          send_tick(plan[i].tick, plan[i].want);
        end else begin
          send_tick(plan[i].tick, advance_spi_engine(plan[i].tick));
        end
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p == 0) begin
        c = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'd0};
      end else if (p == 1) begin
        c = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'd1};
      end else if (p == LONG_PHASE) begin
        c = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'd15};
      end else begin
        c.cpol = 1'($urandom_range(0, 1));
        c.cpha = 1'($urandom_range(0, 1));
        c.msb_first = 1'($urandom_range(0, 1));
        c.three_wire = 1'($urandom_range(0, 1));
        c.wide_words = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        c.half_period_ticks = (r < 5) ? 8'd0 : (r < 8) ? 8'd1 :
                              (r < 9) ? 8'($urandom_range(2, 3)) : 8'($urandom_range(4, 12));
      end
      if (p == 2) write_reg(REG_UNMAPPED, 8'($urandom));
      program_cfg(c);

      if (p == LONG_PHASE) begin
        // One complete framed word at a slow serial clock.
        while (eng_state != ST_IDLE) begin
          t = random_tick();
          t.kind = 1'b0;
          send_tick(t, advance_spi_engine(t));
        end
        t = random_tick();
        t.kind = 1'b1;
        t.cs_take = 1'b1;
        t.cs_end = 1'b1;
        t.rx_wanted = 1'b1;
        send_tick(t, advance_spi_engine(t));
        while (eng_state != ST_IDLE) begin
          t = random_tick();
          t.kind = 1'b0;
          send_tick(t, advance_spi_engine(t));
        end
      end else begin
        for (int i = 0; i < PHASE_TICKS; i++) begin
          t = random_tick();
          send_tick(t, advance_spi_engine(t));
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
